// ===== design/wav_header_parser_defines.svh =====
// Assertion macros for the WAV header parser.
// Expects clk_i and rst_ni in the scope of each use; no other dependencies.
`ifndef WAV_HEADER_PARSER_DEFINES_SVH
`define WAV_HEADER_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset
`define WHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Check a property on every clock edge, reset included
`define WHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define WHP_ASSERT(lbl, prop, msg)
`define WHP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/whp_pkg.sv =====
// Types, constants and the control store of the WAV header parser.
// No dependencies.
`timescale 1ns / 1ps

package whp_pkg;

  // Chunk tags as they appear big-endian in the tag shifter
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  localparam logic [15:0] FMT_PCM      = 16'd1;
  localparam logic [32:0] FMT_BODY_LEN = 33'd16;

  // Result payload width and its byte-padded stream width
  localparam int unsigned RESULT_W = 179;
  localparam int unsigned TDATA_W  = 184;

  // Program steps of the sequencer
  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_RIFF,
    SEQ_WAVE,
    SEQ_FMT_HDR,
    SEQ_FMT_SKIP,
    SEQ_FMT_BODY,
    SEQ_CHECK,
    SEQ_DATA_HDR,
    SEQ_DATA_SKIP
  } step_e;

  // Datapath operation selected by a control word
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_HDR,
    OP_SKIP,
    OP_BODY,
    OP_CHECK
  } op_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NO_RIFF  = 3'd1,
    ST_NOT_WAVE = 3'd2,
    ST_RATE     = 3'd3,
    ST_NON_PCM  = 3'd4,
    ST_SHORT    = 3'd5
  } status_e;

  // One control word
  typedef struct packed {
    op_e         op;
    logic [3:0]  end_pos;    // last byte position of the step
    logic [31:0] tag;        // tag expected at the end of a header
    logic        cap_riff;   // latch the RIFF size at the end
    logic        hit_ok;     // tag match finishes the file
    logic        miss_err;   // tag mismatch is an error
    status_e     err_code;
    step_e       hit_next;   // jump on match, body or skip done, or large skip
    step_e       miss_next;  // jump on mismatch with a nonzero size, or no skip left
  } uc_t;

  typedef struct packed {
    logic [31:0] data_len;
    logic [15:0] smp_bits;
    logic [15:0] frame_len;
    logic [31:0] avg_rate;
    logic [31:0] smp_rate;
    logic [15:0] chan_cnt;
    logic [31:0] riff_len;
    status_e     status;
  } result_t;

  // Control store
  function automatic uc_t uc_rom(step_e s);
    uc_t w;
    w.op        = OP_IDLE;
    w.end_pos   = 4'd0;
    w.tag       = 32'd0;
    w.cap_riff  = 1'b0;
    w.hit_ok    = 1'b0;
    w.miss_err  = 1'b0;
    w.err_code  = ST_OK;
    w.hit_next  = SEQ_IDLE;
    w.miss_next = SEQ_IDLE;
    unique case (s)
      SEQ_RIFF: begin
        w.op = OP_HDR; w.end_pos = 4'd7; w.tag = TAG_RIFF; w.cap_riff = 1'b1;
        w.miss_err = 1'b1; w.err_code = ST_NO_RIFF; w.hit_next = SEQ_WAVE;
      end
      SEQ_WAVE: begin
        w.op = OP_HDR; w.end_pos = 4'd3; w.tag = TAG_WAVE;
        w.miss_err = 1'b1; w.err_code = ST_NOT_WAVE; w.hit_next = SEQ_FMT_HDR;
      end
      SEQ_FMT_HDR: begin
        w.op = OP_HDR; w.end_pos = 4'd7; w.tag = TAG_FMT;
        w.hit_next = SEQ_FMT_BODY; w.miss_next = SEQ_FMT_SKIP;
      end
      SEQ_FMT_SKIP: begin
        w.op = OP_SKIP; w.hit_next = SEQ_FMT_HDR;
      end
      SEQ_FMT_BODY: begin
        w.op = OP_BODY; w.end_pos = 4'd15; w.hit_next = SEQ_CHECK;
      end
      SEQ_CHECK: begin
        w.op = OP_CHECK; w.hit_next = SEQ_DATA_SKIP; w.miss_next = SEQ_DATA_HDR;
      end
      SEQ_DATA_HDR: begin
        w.op = OP_HDR; w.end_pos = 4'd7; w.tag = TAG_DATA; w.hit_ok = 1'b1;
        w.hit_next = SEQ_IDLE; w.miss_next = SEQ_DATA_SKIP;
      end
      SEQ_DATA_SKIP: begin
        w.op = OP_SKIP; w.hit_next = SEQ_DATA_HDR;
      end
      default: begin
        w.op = OP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== design/wav_header_parser.sv =====
// WAV header parser: control-store sequencer over a byte datapath (whp_pkg, defines).
// Results: the result of a byte is registered in the output register or skid stage; after
// the last fmt byte the rate check runs first, in a step of its own.
// Throughput: one byte per cycle, with a stall while the rate check runs and while both
// output register and skid stage hold results.
// Reset (rst_ni low, asynchronous): sequencer idle, output empty; bytes wait for tuser.
`timescale 1ns / 1ps
`include "wav_header_parser_defines.svh"

module wav_header_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [7:0] data_byte
  input  logic                         s_axis_tuser,   // first_byte
  input  logic                         s_axis_tlast,   // last_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [2:0] status, [34:3] riff_len, [50:35] chan_cnt, [82:51] smp_rate,
  // [114:83] avg_rate, [130:115] frame_len, [146:131] smp_bits,
  // [178:147] data_len, [183:179] zero
  output logic [whp_pkg::TDATA_W-1:0] m_axis_tdata
);
  import whp_pkg::*;

  // Sequencer and datapath registers
  step_e       step_q, step_d;
  logic [3:0]  pos_q, pos_d;
  logic        last_q, last_d;
  logic [32:0] skip_q, skip_d;
  logic [31:0] tag_q, tag_d, size_q, size_d;
  logic [31:0] riff_q, riff_d, rate_q, rate_d, avg_q, avg_d;
  logic [15:0] chan_q, chan_d, align_q, align_d, bits_q, bits_d, fmt_q, fmt_d;
  logic [31:0] prod_q;

  // Output register and skid stage
  result_t out_q, skid_q;
  logic    out_valid_q, skid_valid_q;

  // Values seen by the current step (cleared on a first byte)
  logic        accept, restart, go;
  step_e       step_b;
  logic [3:0]  pos_b;
  logic [31:0] tag_b, size_b;
  logic [15:0] fmt_b;
  uc_t         uc;

  logic [31:0] tag_n, size_n;
  logic [32:0] padded, skip_dec;
  logic        pos_end, tag_hit, fmt_bad;
  logic [47:0] prod_full;
  logic [44:0] chk_full;
  logic        rate_bad;
  logic        in_skip;

  logic        res_valid;
  status_e     res_status;
  logic [31:0] res_dsz;
  result_t     res;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign restart = accept && s_axis_tuser;
  assign s_axis_tready = !skid_valid_q && (step_q != SEQ_CHECK);

  // Select the step and clear state on a new file
  assign step_b = restart ? SEQ_RIFF : step_q;
  assign pos_b  = restart ? 4'd0 : pos_q;
  assign tag_b  = restart ? 32'd0 : tag_q;
  assign size_b = restart ? 32'd0 : size_q;
  assign fmt_b  = restart ? 16'd0 : fmt_q;
  assign uc     = uc_rom(step_b);
  assign go     = (uc.op == OP_CHECK) ? !skid_valid_q : accept;

  // Header shifters: tag big-endian, size little-endian
  assign tag_n   = (pos_b < 4'd4 || pos_b >= 4'd8) ? {tag_b[23:0], s_axis_tdata} : tag_b;
  assign size_n  = (pos_b < 4'd4 || pos_b >= 4'd8) ? size_b : {s_axis_tdata, size_b[31:8]};
  assign pos_end = (pos_b == uc.end_pos);
  assign tag_hit = (tag_n == uc.tag);
  assign padded  = {1'b0, size_n} + {32'd0, size_n[0]};
  assign skip_dec = skip_q - 33'd1;
  assign fmt_bad = (pos_b == 4'd13) && (fmt_b != FMT_PCM);

  // Rate check: channels times rate registered, then times bytes per sample
  assign prod_full = rate_q * chan_q;
  assign chk_full  = prod_q * bits_q[15:3];
  assign rate_bad  = (chk_full[31:0] != avg_q);

  // Next state of sequencer and datapath
  always_comb begin : next_state
    step_d  = step_b;
    pos_d   = pos_b;
    last_d  = last_q;
    skip_d  = restart ? 33'd0 : skip_q;
    tag_d   = tag_b;
    size_d  = size_b;
    riff_d  = restart ? 32'd0 : riff_q;
    chan_d  = restart ? 16'd0 : chan_q;
    rate_d  = restart ? 32'd0 : rate_q;
    avg_d   = restart ? 32'd0 : avg_q;
    align_d = restart ? 16'd0 : align_q;
    bits_d  = restart ? 16'd0 : bits_q;
    fmt_d   = fmt_b;
    if (go) begin
      unique case (uc.op)
        OP_HDR: begin
          tag_d  = tag_n;
          size_d = size_n;
          if (pos_end) begin
            pos_d  = 4'd0;
            skip_d = padded;
            if (uc.cap_riff) begin
              riff_d = size_n;
            end
            if (tag_hit) begin
              step_d = uc.hit_next;
            end else if (padded != 33'd0) begin
              step_d = uc.miss_next;
            end
          end else begin
            pos_d = pos_b + 4'd1;
          end
        end
        OP_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == 33'd0) begin
            step_d = uc.hit_next;
            pos_d  = 4'd0;
          end
        end
        OP_BODY: begin
          case (pos_b)
            4'd0:  fmt_d[7:0]     = s_axis_tdata;
            4'd1:  fmt_d[15:8]    = s_axis_tdata;
            4'd2:  chan_d[7:0]    = s_axis_tdata;
            4'd3:  chan_d[15:8]   = s_axis_tdata;
            4'd4:  rate_d[7:0]    = s_axis_tdata;
            4'd5:  rate_d[15:8]   = s_axis_tdata;
            4'd6:  rate_d[23:16]  = s_axis_tdata;
            4'd7:  rate_d[31:24]  = s_axis_tdata;
            4'd8:  avg_d[7:0]     = s_axis_tdata;
            4'd9:  avg_d[15:8]    = s_axis_tdata;
            4'd10: avg_d[23:16]   = s_axis_tdata;
            4'd11: avg_d[31:24]   = s_axis_tdata;
            4'd12: align_d[7:0]   = s_axis_tdata;
            4'd13: align_d[15:8]  = s_axis_tdata;
            4'd14: bits_d[7:0]    = s_axis_tdata;
            default: bits_d[15:8] = s_axis_tdata;
          endcase
          if (pos_end) begin
            step_d = uc.hit_next;
            pos_d  = 4'd0;
            last_d = s_axis_tlast;
          end else begin
            pos_d = pos_b + 4'd1;
          end
        end
        OP_CHECK: begin
          if (skip_q > FMT_BODY_LEN) begin
            skip_d = skip_q - FMT_BODY_LEN;
            step_d = uc.hit_next;
          end else begin
            skip_d = 33'd0;
            step_d = uc.miss_next;
          end
        end
        default: begin
          step_d = step_b;
        end
      endcase
    end
    // Drop back to idle once the file has its result
    if (res_valid) begin
      step_d = SEQ_IDLE;
      pos_d  = 4'd0;
    end
  end

  // Result decision
  always_comb begin : result_dec
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_dsz    = 32'd0;
    if (go) begin
      unique case (uc.op)
        OP_HDR: begin
          if (pos_end && uc.miss_err && !tag_hit) begin
            res_valid  = 1'b1;
            res_status = uc.err_code;
          end else if (pos_end && uc.hit_ok && tag_hit) begin
            res_valid  = 1'b1;
            res_status = ST_OK;
            res_dsz    = size_n;
          end
        end
        OP_BODY: begin
          if (fmt_bad) begin
            res_valid  = 1'b1;
            res_status = ST_NON_PCM;
          end
        end
        OP_CHECK: begin
          if (rate_bad) begin
            res_valid  = 1'b1;
            res_status = ST_RATE;
          end else if (last_q) begin
            res_valid  = 1'b1;
            res_status = ST_SHORT;
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
    // Early end; the final fmt byte defers it to the rate check
    if (!res_valid && accept && s_axis_tlast && step_b != SEQ_IDLE &&
        !(uc.op == OP_BODY && pos_end)) begin
      res_valid  = 1'b1;
      res_status = ST_SHORT;
      res_dsz    = 32'd0;
    end
  end

  // Assemble the result from the updated fields
  always_comb begin : result_pack
    res.status    = res_status;
    res.riff_len  = riff_d;
    res.chan_cnt  = chan_d;
    res.smp_rate  = rate_d;
    res.avg_rate  = avg_d;
    res.frame_len = align_d;
    res.smp_bits  = bits_d;
    res.data_len  = res_dsz;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= SEQ_IDLE;
      pos_q  <= 4'd0;
      last_q <= 1'b0;
    end else begin
      step_q <= step_d;
      pos_q  <= pos_d;
      last_q <= last_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    skip_q  <= skip_d;
    tag_q   <= tag_d;
    size_q  <= size_d;
    riff_q  <= riff_d;
    chan_q  <= chan_d;
    rate_q  <= rate_d;
    avg_q   <= avg_d;
    align_q <= align_d;
    bits_q  <= bits_d;
    fmt_q   <= fmt_d;
    prod_q  <= prod_full[31:0];
  end

  // Output register and skid stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output register and skid stage payload
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_q <= skid_valid_q ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q.data_len, out_q.smp_bits, out_q.frame_len,
                          out_q.avg_rate, out_q.smp_rate, out_q.chan_cnt,
                          out_q.riff_len, out_q.status};

  // Assertions
  assign in_skip = (step_q == SEQ_FMT_SKIP) || (step_q == SEQ_DATA_SKIP);

  `WHP_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid ahead of output")
  `WHP_ASSERT(a_check_stalls, (step_q == SEQ_CHECK) |-> !s_axis_tready, "byte in rate check")
  `WHP_ASSERT(a_result_idles, res_valid |=> (step_q == SEQ_IDLE && pos_q == 4'd0), "busy")
  `WHP_ASSERT(a_skip_nonzero, in_skip |-> (skip_q != 33'd0), "skip step with nothing to skip")
  `WHP_ASSERT(a_no_result_when_full, skid_valid_q |-> !res_valid, "result with both slots full")

endmodule
